FILE: design/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg: shared definitions for the SLIP frame decoder
// SLIP framing codes, field widths and the per-byte result word.
// ---------------------------------------------------------------------------
package sfd_pkg;

    localparam logic [7:0] CODE_FEND  = 8'hC0;
    localparam logic [7:0] CODE_FESC  = 8'hDB;
    localparam logic [7:0] CODE_TFEND = 8'hDC;
    localparam logic [7:0] CODE_TFESC = 8'hDD;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 13;

    localparam int          MAX_FRAME_BYTES_DEF = 4096;
    localparam logic [12:0] LIMIT_RESET         = 13'd4096;

    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_done;
        logic [LEN_W-1:0]  frame_len;
        logic              frame_abort;
    } result_t;

endpackage

FILE: design/slip_frame_decoder_unit.sv
// ---------------------------------------------------------------------------
// slip_frame_decoder_unit: SLIP receive-side frame decoder
// Decodes a raw SLIP byte stream into payload bytes and frame events.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one raw link byte per
//   word. Output channel (out_valid / out_stall) returns exactly one result
//   word per input word: a decoded byte (data_valid), a completed frame
//   (frame_done with frame_len) or a dropped frame (frame_abort); words for
//   framing bytes or ignored bytes carry all flags low.
//   A result word is registered in the buffer, so out_valid rises in the cycle
//   after input accept. Throughput is one word per cycle while in_stall is low.
//   A two-word result buffer sits between the sides: with out_stall high the
//   unit keeps taking input until both entries hold results, then raises
//   in_stall until the receiver takes a word.
//   cfg_wr_en / cfg_wr_data load the frame length limit (reset 4096); a
//   value above MAX_FRAME_BYTES acts as MAX_FRAME_BYTES. Write it only
//   while the unit is idle.
//   Reset clears the buffer and returns the decoder to hunting for the
//   first END; bytes before it are ignored.
// ---------------------------------------------------------------------------
module slip_frame_decoder_unit #(
    parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [sfd_pkg::LEN_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       data_valid,
    output logic [sfd_pkg::BYTE_W-1:0] data_byte,
    output logic                       frame_done,
    output logic [sfd_pkg::LEN_W-1:0]  frame_len,
    output logic                       frame_abort
);

    logic [sfd_pkg::LEN_W-1:0] limit_reg;
    logic                      accept;
    logic                      buf_full;
    sfd_pkg::result_t          step_res;
    sfd_pkg::result_t          out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= sfd_pkg::LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    sfd_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .limit_cfg (limit_reg),
        .res       (step_res)
    );

    sfd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_data  (step_res),
        .full     (buf_full),
        .rd_valid (out_valid),
        .rd_stall (out_stall),
        .rd_data  (out_res)
    );

    assign data_valid  = out_res.data_valid;
    assign data_byte   = out_res.data_byte;
    assign frame_done  = out_res.frame_done;
    assign frame_len   = out_res.frame_len;
    assign frame_abort = out_res.frame_abort;

`ifndef ASSERT_OFF
    // one event kind per result word
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((frame_done && frame_abort) || (data_valid && frame_done)
                        || (data_valid && frame_abort)))
        else $error("more than one event in a result word");

    // a completed frame is never empty
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (frame_len != '0))
        else $error("frame_done with zero length");

    // full buffer means a result is on offer
    a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty result buffer");

    // an accepted byte shows up as a result on the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted word produced no result");
`endif

endmodule

FILE: design/sfd_core.sv
// ---------------------------------------------------------------------------
// sfd_core: SLIP decode state and per-byte result
// Holds the frame state, updates it on each accepted byte and forms the
// result word for that byte in the same cycle.
// ---------------------------------------------------------------------------
module sfd_core #(
    parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
    input  logic [sfd_pkg::LEN_W-1:0]  limit_cfg,
    output sfd_pkg::result_t           res
);

    logic                      in_frame_reg, in_frame_next;
    logic                      escape_seen_reg, escape_seen_next;
    logic                      dropping_reg, dropping_next;
    logic [sfd_pkg::LEN_W-1:0] byte_count_reg, byte_count_next;
    logic [sfd_pkg::LEN_W-1:0] limit;
    logic                      have_byte;
    logic [sfd_pkg::BYTE_W-1:0] decoded;

    // effective limit saturates to the build-time maximum
    always_comb
    begin
        if ({19'd0, limit_cfg} > 32'(MAX_FRAME_BYTES))
            limit = sfd_pkg::LEN_W'(MAX_FRAME_BYTES);
        else
            limit = limit_cfg;
    end

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        escape_seen_next = escape_seen_reg;
        dropping_next    = dropping_reg;
        byte_count_next  = byte_count_reg;
        res              = '0;
        have_byte        = 1'b0;
        decoded          = '0;

        if (rx_byte == sfd_pkg::CODE_FEND)
        begin
            if (!in_frame_reg)
            begin
                in_frame_next    = 1'b1;
                escape_seen_next = 1'b0;
                dropping_next    = 1'b0;
                byte_count_next  = '0;
            end
            else if (dropping_reg)
            begin
                escape_seen_next = 1'b0;
                dropping_next    = 1'b0;
                byte_count_next  = '0;
            end
            else if (escape_seen_reg)
            begin
                res.frame_abort  = 1'b1;
                escape_seen_next = 1'b0;
                byte_count_next  = '0;
            end
            else if (byte_count_reg != '0)
            begin
                res.frame_done  = 1'b1;
                res.frame_len   = byte_count_reg;
                byte_count_next = '0;
            end
        end
        else if (in_frame_reg && !dropping_reg)
        begin
            if (escape_seen_reg)
            begin
                escape_seen_next = 1'b0;
                if (rx_byte == sfd_pkg::CODE_TFEND)
                begin
                    have_byte = 1'b1;
                    decoded   = sfd_pkg::CODE_FEND;
                end
                else if (rx_byte == sfd_pkg::CODE_TFESC)
                begin
                    have_byte = 1'b1;
                    decoded   = sfd_pkg::CODE_FESC;
                end
                else
                begin
                    dropping_next   = 1'b1;
                    res.frame_abort = 1'b1;
                end
            end
            else if (rx_byte == sfd_pkg::CODE_FESC)
                escape_seen_next = 1'b1;
            else
            begin
                have_byte = 1'b1;
                decoded   = rx_byte;
            end

            if (have_byte)
            begin
                if (byte_count_reg >= limit)
                begin
                    dropping_next   = 1'b1;
                    res.frame_abort = 1'b1;
                end
                else
                begin
                    byte_count_next = byte_count_reg + sfd_pkg::LEN_W'(1);
                    res.data_valid  = 1'b1;
                    res.data_byte   = decoded;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            escape_seen_reg <= 1'b0;
            dropping_reg    <= 1'b0;
            byte_count_reg  <= '0;
        end
        else if (accept)
        begin
            in_frame_reg    <= in_frame_next;
            escape_seen_reg <= escape_seen_next;
            dropping_reg    <= dropping_next;
            byte_count_reg  <= byte_count_next;
        end
    end

endmodule

FILE: design/sfd_out_buf.sv
// ---------------------------------------------------------------------------
// sfd_out_buf: two-entry result buffer
// Registers result words and lets the input side keep going while the
// receiver stalls, until both entries are full. Full flag is registered.
// ---------------------------------------------------------------------------
module sfd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  sfd_pkg::result_t wr_data,
    output logic             full,
    output logic             rd_valid,
    input  logic             rd_stall,
    output sfd_pkg::result_t rd_data
);

    sfd_pkg::result_t mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             rd_en;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_en    = rd_valid && !rd_stall;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: tb/sv/slip_frame_decoder_unit_test.sv
// ---------------------------------------------------------------------------
// slip_frame_decoder_unit_test: self-checking bench for the SLIP decoder
// Feeds raw link bytes, from hand-picked framing corners and from random
// frames, good and broken, under several frame limits and idle patterns.
// It predicts one result word per accepted byte and compares the fields.
// ---------------------------------------------------------------------------
module slip_frame_decoder_unit_test;

    localparam int MAX_BYTES   = sfd_pkg::MAX_FRAME_BYTES_DEF;
    localparam int HOLD_CYCLES = 80;
    localparam int STUCK_LIMIT = 2000;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_ESC,
        FRAME_ESC_THEN_END
    } frame_kind_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [sfd_pkg::LEN_W-1:0]  cfg_wr_data = '0;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte     = '0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic                       data_valid;
    logic [sfd_pkg::BYTE_W-1:0] data_byte;
    logic                       frame_done;
    logic [sfd_pkg::LEN_W-1:0]  frame_len;
    logic                       frame_abort;

    // decoder shadow state
    logic                      synced       = 1'b0;
    logic                      esc_pending  = 1'b0;
    logic                      discarding   = 1'b0;
    logic [sfd_pkg::LEN_W-1:0] frame_count  = '0;
    logic [sfd_pkg::LEN_W-1:0] limit_shadow = sfd_pkg::LIMIT_RESET;

    logic [sfd_pkg::BYTE_W-1:0] link_bytes[$];
    sfd_pkg::result_t           pending_results[$];

    logic word_taken   = 1'b0;
    int   gap_pct      = 0;
    int   stall_pct    = 0;
    int   hold_asks    = 0;
    int   hold_seen    = 0;
    int   hold_left    = 0;
    int   stuck_cycles = 0;
    int   mismatches   = 0;
    int   phase_items  = 0;

    slip_frame_decoder_unit #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_valid (data_valid),
        .data_byte  (data_byte),
        .frame_done (frame_done),
        .frame_len  (frame_len),
        .frame_abort(frame_abort)
    );

    always #5 clk = ~clk;

    function automatic sfd_pkg::result_t decode_slip_byte(
        input logic [sfd_pkg::BYTE_W-1:0] b);
        sfd_pkg::result_t           r;
        logic                       have;
        logic [sfd_pkg::BYTE_W-1:0] value;
        int                         cap;
        r     = '0;
        have  = 1'b0;
        value = '0;
        cap   = (int'(limit_shadow) > MAX_BYTES) ? MAX_BYTES : int'(limit_shadow);
        if (b == sfd_pkg::CODE_FEND)
        begin
            // END while hunting or dropping just (re)opens a frame
            if (synced && !discarding)
            begin
                if (esc_pending)
                begin
                    r.frame_abort = 1'b1;
                end
                else if (frame_count != '0)
                begin
                    r.frame_done = 1'b1;
                    r.frame_len  = frame_count;
                end
            end
            synced      = 1'b1;
            esc_pending = 1'b0;
            discarding  = 1'b0;
            frame_count = '0;
        end
        else if (synced && !discarding)
        begin
            if (esc_pending)
            begin
                esc_pending = 1'b0;
                if (b == sfd_pkg::CODE_TFEND)
                begin
                    have  = 1'b1;
                    value = sfd_pkg::CODE_FEND;
                end
                else if (b == sfd_pkg::CODE_TFESC)
                begin
                    have  = 1'b1;
                    value = sfd_pkg::CODE_FESC;
                end
                else
                begin
                    discarding    = 1'b1;
                    r.frame_abort = 1'b1;
                end
            end
            else if (b == sfd_pkg::CODE_FESC)
            begin
                esc_pending = 1'b1;
            end
            else
            begin
                have  = 1'b1;
                value = b;
            end
            if (have)
            begin
                if (int'(frame_count) >= cap)
                begin
                    discarding    = 1'b1;
                    r.frame_abort = 1'b1;
                end
                else
                begin
                    frame_count  = frame_count + sfd_pkg::LEN_W'(1);
                    r.data_valid = 1'b1;
                    r.data_byte  = value;
                end
            end
        end
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // sender: next word only once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || word_taken))
        begin
            if (link_bytes.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                rx_byte  <= link_bytes.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall, or a long hold when asked
    always @(negedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // accept, predict and check
    always @(posedge clk)
    begin
        sfd_pkg::result_t want;
        word_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            pending_results.push_back(decode_slip_byte(rx_byte));
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("data_valid", int'(want.data_valid), int'(data_valid));
                report_field("data_byte", int'(want.data_byte), int'(data_byte));
                report_field("frame_done", int'(want.frame_done), int'(frame_done));
                report_field("frame_len", int'(want.frame_len), int'(frame_len));
                report_field("frame_abort", int'(want.frame_abort), int'(frame_abort));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic put(input logic [sfd_pkg::BYTE_W-1:0] b);
        link_bytes.push_back(b);
        phase_items++;
    endtask

    // payload biased toward the two bytes that need escaping
    function automatic logic [sfd_pkg::BYTE_W-1:0] pick_payload();
        case ($urandom_range(9))
            0, 1:    return sfd_pkg::CODE_FEND;
            2, 3:    return sfd_pkg::CODE_FESC;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic put_encoded(input logic [sfd_pkg::BYTE_W-1:0] b);
        if (b == sfd_pkg::CODE_FEND)
        begin
            put(sfd_pkg::CODE_FESC);
            put(sfd_pkg::CODE_TFEND);
        end
        else if (b == sfd_pkg::CODE_FESC)
        begin
            put(sfd_pkg::CODE_FESC);
            put(sfd_pkg::CODE_TFESC);
        end
        else
        begin
            put(b);
        end
    endtask

    task automatic put_frame(input int len, input frame_kind_t kind);
        int                         cut;
        logic [sfd_pkg::BYTE_W-1:0] junk;
        cut = $urandom_range(len);
        for (int i = 0; i <= len; i++)
        begin
            if (kind == FRAME_BAD_ESC && i == cut)
            begin
                do
                    junk = 8'($urandom_range(255));
                while (junk == sfd_pkg::CODE_TFEND || junk == sfd_pkg::CODE_TFESC
                       || junk == sfd_pkg::CODE_FEND);
                put(sfd_pkg::CODE_FESC);
                put(junk);
            end
            if (i < len)
                put_encoded(pick_payload());
        end
        if (kind == FRAME_ESC_THEN_END)
            put(sfd_pkg::CODE_FESC);
        put(sfd_pkg::CODE_FEND);
    endtask

    task automatic put_random_traffic(input int n_items, input int max_len);
        int roll;
        phase_items = 0;
        while (phase_items < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                put_frame($urandom_range(max_len), FRAME_GOOD);
            end
            else if (roll < 80)
            begin
                put_frame($urandom_range(max_len), FRAME_BAD_ESC);
            end
            else if (roll < 88)
            begin
                put_frame($urandom_range(max_len), FRAME_ESC_THEN_END);
            end
            else
            begin
                // line noise, then resync
                repeat ($urandom_range(1, 6))
                    put(8'($urandom_range(255)));
                put(sfd_pkg::CODE_FEND);
            end
        end
    endtask

    task automatic wait_idle();
        while (link_bytes.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [sfd_pkg::LEN_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        limit_shadow = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int lim;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ignored until the first END
        put(8'h00);
        put(8'hFF);
        put(sfd_pkg::CODE_FESC);
        put(sfd_pkg::CODE_TFESC);
        put(sfd_pkg::CODE_FEND);
        put(sfd_pkg::CODE_FEND);
        // both escapes decoded, frame of four
        put(8'h00);
        put(8'hFF);
        put(sfd_pkg::CODE_FESC);
        put(sfd_pkg::CODE_TFEND);
        put(sfd_pkg::CODE_FESC);
        put(sfd_pkg::CODE_TFESC);
        put(sfd_pkg::CODE_FEND);
        // bad escape, byte ignored while dropping, END with no second abort
        put(sfd_pkg::CODE_FESC);
        put(8'h41);
        put(8'h55);
        put(sfd_pkg::CODE_FEND);
        // END while an escape is pending
        put(sfd_pkg::CODE_FESC);
        put(sfd_pkg::CODE_FEND);
        put(8'h12);
        put(sfd_pkg::CODE_FEND);
        put_random_traffic(130, 40);
        wait_idle();

        write_limit(13'd1);
        gap_pct = 77;
        put(8'h33);
        put(8'h44);
        put(sfd_pkg::CODE_FEND);
        put(8'h5A);
        put(sfd_pkg::CODE_FEND);
        put_random_traffic(150, 3);
        wait_idle();

        // zero limit: first byte of any frame overflows
        write_limit(13'd0);
        gap_pct   = 0;
        stall_pct = 77;
        put(8'h33);
        put(sfd_pkg::CODE_FEND);
        put_random_traffic(120, 4);
        hold_asks++;
        wait_idle();

        lim = $urandom_range(8, 40);
        write_limit(sfd_pkg::LEN_W'(lim));
        gap_pct   = 12;
        stall_pct = 12;
        put_random_traffic(200, lim + 3);
        hold_asks++;
        wait_idle();

        // limit register above the build maximum
        write_limit(13'h1FFF);
        gap_pct   = 0;
        stall_pct = 0;
        put_random_traffic(150, 40);
        wait_idle();

        write_limit(sfd_pkg::LIMIT_RESET);
        gap_pct   = 12;
        stall_pct = 12;
        put_random_traffic(50, 40);
        wait_idle();

        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
